>>> design/gcs_pkg.sv
`timescale 1ns / 1ps
// Shared constants and codes for the gradient color sampler.
// Used by the top level and the testbench; no dependencies.
package gcs_pkg;

    localparam int TABLE_DEPTH  = 16;
    localparam int CHANNEL_BITS = 16;
    localparam int CHANNELS     = 4;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);
    localparam int COLOR_W      = CHANNELS * CHANNEL_BITS;

    localparam int POS_W        = 24;
    localparam int FRAC_W       = 16;
    localparam int T_W          = FRAC_W + 1;
    localparam int SCALE_W      = 16;
    localparam int PROD_W       = T_W + SCALE_W;
    localparam int WEIGHT_W     = 16;
    localparam int MASK_W       = 4;
    localparam int COUNT_W      = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd4096;
    localparam logic [MASK_W-1:0]  MASK_RESET  = 4'd15;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

    typedef enum logic [1:0] {
        WRAP_REPEAT  = 2'd0,
        WRAP_REFLECT = 2'd1,
        WRAP_CLAMP   = 2'd2
    } wrap_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WRAP_MODE      = 2'd0,
        CFG_SCALE          = 2'd1,
        CFG_INDEX_MASK     = 2'd2,
        CFG_ENTRIES_IN_USE = 2'd3
    } cfg_index_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_LOAD   = 1'b1
    } operation_t;

endpackage

>>> design/gradient_color_sampler.sv
`timescale 1ns / 1ps
// Gradient color sampler top level: spread mapping, scaling, table read, interpolation.
// Depends on gcs_pkg and gcs_ram.
//
//  channel | signals                                 | direction
//  --------+-----------------------------------------+-----------
//  in      | in_valid, in_stall, operation, position,| request in
//          | entry_index, entry_red..entry_alpha     |
//  out     | out_valid, out_stall, out_red..out_alpha| result out
//  cfg     | cfg_write, cfg_index, cfg_data          | write only
//
// One request per cycle unless stalled; results leave from the output register.
// Rate is set by the two table read ports (one RAM copy per port) and the
// scale and blend multipliers, each followed by a register.
// Loads write the table in the same stage that samples read it, so order holds.
// Reset clears valid flags and sets configuration to its defaults; table contents stay undefined.
// Stalls propagate stage by stage; empty stages still take new requests.
module gradient_color_sampler (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 operation,
    input  logic signed [gcs_pkg::POS_W-1:0]     position,
    input  logic [3:0]                           entry_index,
    input  logic [15:0]                          entry_red,
    input  logic [15:0]                          entry_green,
    input  logic [15:0]                          entry_blue,
    input  logic [15:0]                          entry_alpha,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [15:0]                          out_red,
    output logic [15:0]                          out_green,
    output logic [15:0]                          out_blue,
    output logic [15:0]                          out_alpha,
    input  logic                                 cfg_write,
    input  logic [gcs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gcs_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int IW = gcs_pkg::IDX_W;
    localparam int CB = gcs_pkg::CHANNEL_BITS;

    // configuration
    logic [1:0]                    wrap_mode_reg;
    logic [gcs_pkg::SCALE_W-1:0]   scale_reg;
    logic [gcs_pkg::MASK_W-1:0]    index_mask_reg;
    logic [gcs_pkg::COUNT_W-1:0]   entries_reg;

    // handshake enables
    logic en_out, en3, en2, en1;

    // stage 1
    logic                          s1_valid_reg, s1_load_reg, s1_force_reg;
    logic [gcs_pkg::T_W-1:0]       s1_t_reg, s1_t_next;
    logic                          s1_force_next;
    logic [IW-1:0]                 s1_end_reg, s1_end_next;
    logic [IW-1:0]                 s1_widx_reg;
    logic [gcs_pkg::COLOR_W-1:0]   s1_color_reg;

    // stage 2
    logic                          s2_valid_reg, s2_load_reg, s2_force_reg;
    logic [gcs_pkg::PROD_W-1:0]    s2_prod_reg, s2_prod_next;
    logic [IW-1:0]                 s2_end_reg, s2_widx_reg;
    logic [gcs_pkg::COLOR_W-1:0]   s2_color_reg;

    // stage 3
    logic                          s3_valid_reg;
    logic [gcs_pkg::WEIGHT_W-1:0]  s3_w_reg, s3_w_next;
    logic [IW-1:0]                 rd0_addr, rd1_addr;
    logic                          tbl_we;
    logic [gcs_pkg::COLOR_W-1:0]   rd0_data, rd1_data;

    // output
    logic                          out_valid_reg;
    logic [gcs_pkg::COLOR_W-1:0]   out_color_reg, out_color_next;

    assign en_out   = !out_valid_reg || !out_stall;
    assign en3      = !s3_valid_reg || en_out;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_mode_reg  <= gcs_pkg::WRAP_REPEAT;
            scale_reg      <= gcs_pkg::SCALE_RESET;
            index_mask_reg <= gcs_pkg::MASK_RESET;
            entries_reg    <= gcs_pkg::COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                gcs_pkg::CFG_WRAP_MODE:      wrap_mode_reg  <= cfg_data[1:0];
                gcs_pkg::CFG_SCALE:          scale_reg      <= cfg_data[15:0];
                gcs_pkg::CFG_INDEX_MASK:     index_mask_reg <= cfg_data[3:0];
                gcs_pkg::CFG_ENTRIES_IN_USE: entries_reg    <= cfg_data[4:0];
                default:                     wrap_mode_reg  <= wrap_mode_reg;
            endcase
        end
    end

    // stage 1: spread mapping
    always_comb
    begin
        logic [gcs_pkg::POS_W-1:0] neg;
        logic [gcs_pkg::POS_W-1:0] mag;
        logic [15:0]               frac;
        neg           = '0 - position;
        mag           = position;
        frac          = '0;
        s1_t_next     = '0;
        s1_force_next = 1'b0;
        s1_end_next   = '0;
        if (position[23])
        begin
            mag = (position == 24'sh800000) ? 24'h7FFFFF : neg;
        end
        frac = mag[15:0];
        priority if (wrap_mode_reg == gcs_pkg::WRAP_REPEAT
                     || wrap_mode_reg == gcs_pkg::WRAP_REFLECT)
        begin
            s1_t_next = {1'b0, frac};
            if (wrap_mode_reg == gcs_pkg::WRAP_REFLECT && mag[16])
            begin
                s1_t_next = 17'h10000 - {1'b0, frac};
            end
        end
        else if (position[23] || position == '0)
        begin
            s1_force_next = 1'b1;
        end
        else if (position[22:16] != '0)
        begin
            s1_force_next = 1'b1;
            priority if (entries_reg == '0)
                s1_end_next = '0;
            else if (entries_reg > gcs_pkg::COUNT_W'(gcs_pkg::TABLE_DEPTH))
                s1_end_next = IW'(gcs_pkg::TABLE_DEPTH - 1);
            else
                s1_end_next = IW'(entries_reg - 1'b1);
        end
        else
        begin
            s1_t_next = {1'b0, position[15:0]};
        end
    end

    // stage 2: scale
    assign s2_prod_next = gcs_pkg::PROD_W'(s1_t_reg) * gcs_pkg::PROD_W'(scale_reg);

    // stage 3: index, weight, table access
    always_comb
    begin
        logic [IW-1:0] idx0;
        idx0      = s2_prod_reg[24 +: IW];
        rd0_addr  = idx0 & IW'(index_mask_reg);
        rd1_addr  = (idx0 + 1'b1) & IW'(index_mask_reg);
        s3_w_next = s2_prod_reg[23:8];
        if (s2_force_reg)
        begin
            rd0_addr  = s2_end_reg;
            rd1_addr  = s2_end_reg;
            s3_w_next = '0;
        end
    end

    assign tbl_we = en3 && s2_valid_reg && s2_load_reg;

    gcs_ram #(.WIDTH(gcs_pkg::COLOR_W), .DEPTH(gcs_pkg::TABLE_DEPTH)) u_ram0 (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (s2_widx_reg),
        .wdata (s2_color_reg),
        .re    (en3),
        .raddr (rd0_addr),
        .rdata (rd0_data)
    );

    gcs_ram #(.WIDTH(gcs_pkg::COLOR_W), .DEPTH(gcs_pkg::TABLE_DEPTH)) u_ram1 (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (s2_widx_reg),
        .wdata (s2_color_reg),
        .re    (en3),
        .raddr (rd1_addr),
        .rdata (rd1_data)
    );

    // stage 4: blend, out = a + ((b - a) * w) >>> 16
    always_comb
    begin
        logic signed [CB:0]       diff;
        logic signed [2*CB+1:0]   prod;
        logic [CB-1:0]            a;
        logic [CB-1:0]            b;
        for (int c = 0; c < gcs_pkg::CHANNELS; c++)
        begin
            a    = rd0_data[c*CB +: CB];
            b    = rd1_data[c*CB +: CB];
            diff = $signed({1'b0, b}) - $signed({1'b0, a});
            prod = diff * $signed({1'b0, s3_w_reg});
            out_color_next[c*CB +: CB] = a + prod[16 +: CB];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg && !s2_load_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_load_reg  <= (operation == gcs_pkg::OP_LOAD);
            s1_t_reg     <= s1_t_next;
            s1_force_reg <= s1_force_next;
            s1_end_reg   <= s1_end_next;
            s1_widx_reg  <= entry_index[IW-1:0];
            s1_color_reg <= {entry_alpha, entry_blue, entry_green, entry_red};
        end
        if (en2)
        begin
            s2_load_reg  <= s1_load_reg;
            s2_prod_reg  <= s2_prod_next;
            s2_force_reg <= s1_force_reg;
            s2_end_reg   <= s1_end_reg;
            s2_widx_reg  <= s1_widx_reg;
            s2_color_reg <= s1_color_reg;
        end
        if (en3)
        begin
            s3_w_reg <= s3_w_next;
        end
        if (en_out)
        begin
            out_color_reg <= out_color_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = out_color_reg[0*CB +: CB];
    assign out_green = out_color_reg[1*CB +: CB];
    assign out_blue  = out_color_reg[2*CB +: CB];
    assign out_alpha = out_color_reg[3*CB +: CB];

endmodule

>>> design/gcs_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// Self-contained; instanced by the gradient color sampler for its color table.
module gcs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> tb/gradient_color_sampler_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for gradient_color_sampler: table loads, all spread modes and
// register settings, random request gaps and result stalls, in-bench color prediction.
// Depends on gcs_pkg and the gradient_color_sampler RTL.
module gradient_color_sampler_tb;

    localparam int PERIOD_NS    = 12;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASES       = 10;
    localparam int PER_PHASE    = 95;
    localparam int SETTLE       = 8;
    localparam int REPORT_MAX   = 10;
    localparam logic [1:0] WRAP_UNUSED = 2'd3;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
    } color_t;

    typedef struct packed {
        logic                 is_cfg;
        gcs_pkg::cfg_index_t  reg_sel;
        logic [15:0]          reg_val;
        gcs_pkg::operation_t  op;
        logic [23:0]          pos;
        logic [3:0]           idx;
        color_t               color;
        logic                 typed;
        color_t               want;
    } step_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        operation;
    logic [23:0] position;
    logic [3:0]  entry_index;
    logic [15:0] entry_red;
    logic [15:0] entry_green;
    logic [15:0] entry_blue;
    logic [15:0] entry_alpha;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;
    logic        cfg_write;
    logic [gcs_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [gcs_pkg::CFG_DATA_W-1:0] cfg_data;

    color_t      palette [gcs_pkg::TABLE_DEPTH];
    logic [1:0]  wrap_q;
    logic [15:0] scale_q;
    logic [3:0]  mask_q;
    logic [4:0]  count_q;

    color_t      pending_colors [$];
    step_t       directed_plan [33];
    int          failures;
    int          cycles;
    int          samples_sent;
    int          loads_sent;
    int          reg_writes;
    int          colors_checked;

    gradient_color_sampler i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .position    (position),
        .entry_index (entry_index),
        .entry_red   (entry_red),
        .entry_green (entry_green),
        .entry_blue  (entry_blue),
        .entry_alpha (entry_alpha),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue),
        .out_alpha   (out_alpha),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(PERIOD_NS / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d colors outstanding",
                     cycles, pending_colors.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [15:0] mix_channel(logic [15:0] lo, logic [15:0] hi,
                                                longint unsigned w);
        longint unsigned acc;
        acc = longint'(lo) * (65536 - w) + longint'(hi) * w;
        return acc[31:16];
    endfunction

    function automatic color_t blend_at(longint unsigned t);
        longint unsigned s;
        longint unsigned idx;
        longint unsigned w;
        int              i0;
        int              i1;
        color_t          a;
        color_t          b;
        color_t          r;
        s   = t * scale_q;
        idx = s >> 24;
        w   = (s >> 8) & 64'hFFFF;
        i0  = int'((idx & mask_q) % gcs_pkg::TABLE_DEPTH);
        i1  = int'(((idx + 1) & mask_q) % gcs_pkg::TABLE_DEPTH);
        a   = palette[i0];
        b   = palette[i1];
        r.red   = mix_channel(a.red,   b.red,   w);
        r.green = mix_channel(a.green, b.green, w);
        r.blue  = mix_channel(a.blue,  b.blue,  w);
        r.alpha = mix_channel(a.alpha, b.alpha, w);
        return r;
    endfunction

    function automatic color_t sample_gradient(logic [23:0] raw);
        int          p;
        int          last;
        logic [23:0] mag;
        logic [16:0] t;
        p = int'($signed(raw));
        if (wrap_q >= gcs_pkg::WRAP_CLAMP)
        begin
            if (p <= 0)
                return palette[0];
            if (p >= 65536)
            begin
                last = (count_q == 0) ? 0 : int'(count_q) - 1;
                if (last > gcs_pkg::TABLE_DEPTH - 1)
                    last = gcs_pkg::TABLE_DEPTH - 1;
                return palette[last];
            end
            return blend_at(longint'(p));
        end
        if (p == -8388608)
            mag = 24'h7FFFFF;
        else if (p < 0)
            mag = 24'(-p);
        else
            mag = 24'(p);
        t = {1'b0, mag[15:0]};
        if (wrap_q == gcs_pkg::WRAP_REFLECT && mag[16])
            t = 17'h10000 - t;
        return blend_at(longint'(t));
    endfunction

    function automatic step_t load_row(logic [3:0] idx, color_t c);
        step_t s;
        s       = '0;
        s.op    = gcs_pkg::OP_LOAD;
        s.idx   = idx;
        s.color = c;
        s.pos   = 24'hFFFFFF;
        return s;
    endfunction

    function automatic step_t sample_row(logic [23:0] pos);
        step_t s;
        s       = '0;
        s.op    = gcs_pkg::OP_SAMPLE;
        s.pos   = pos;
        s.idx   = 4'hA;
        s.color = {4{16'hA5A5}};
        return s;
    endfunction

    function automatic step_t sample_row_is(logic [23:0] pos, color_t want);
        step_t s;
        s       = sample_row(pos);
        s.typed = 1'b1;
        s.want  = want;
        return s;
    endfunction

    function automatic step_t reg_row(gcs_pkg::cfg_index_t sel, logic [15:0] val);
        step_t s;
        s         = '0;
        s.is_cfg  = 1'b1;
        s.reg_sel = sel;
        s.reg_val = val;
        return s;
    endfunction

    function automatic logic [15:0] pick_channel();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] pick_position();
        case ($urandom_range(0, 7))
            0: return 24'($urandom_range(0, 16'hFFFF));
            1: return 24'($urandom_range(0, 24'h2FFFF));
            2: return -24'($urandom_range(0, 24'h2FFFF));
            3: return {8'($urandom), 16'h0000};
            4:
            begin
                case ($urandom_range(0, 5))
                    0:       return 24'h000000;
                    1:       return 24'h7FFFFF;
                    2:       return 24'h800000;
                    3:       return 24'hFFFFFF;
                    4:       return 24'h010000;
                    default: return 24'h00FFFF;
                endcase
            end
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_scale();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h0100;
            3:       return gcs_pkg::SCALE_RESET;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic flag_failure(string what);
        failures++;
        if (failures <= REPORT_MAX)
            $display("mismatch %0d: %s", failures, what);
    endtask

    task automatic issue(step_t s);
        logic taken;
        in_valid    <= 1'b1;
        operation   <= s.op;
        position    <= s.pos;
        entry_index <= s.idx;
        entry_red   <= s.color.red;
        entry_green <= s.color.green;
        entry_blue  <= s.color.blue;
        entry_alpha <= s.color.alpha;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        if (s.op == gcs_pkg::OP_LOAD)
        begin
            palette[s.idx % gcs_pkg::TABLE_DEPTH] = s.color;
            loads_sent++;
        end
        else
        begin
            pending_colors.push_back(s.typed ? s.want : sample_gradient(s.pos));
            samples_sent++;
        end
    endtask

    task automatic idle_gap(bit calm);
        int n;
        case ($urandom_range(0, 19))
            0, 1:    n = $urandom_range(8, 40);
            2, 3, 4, 5, 6, 7: n = $urandom_range(1, 3);
            default: n = 0;
        endcase
        if (!calm && n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // drain results, then let trailing loads clear the pipe
    task automatic quiesce();
        in_valid <= 1'b0;
        while (pending_colors.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(gcs_pkg::cfg_index_t sel, logic [15:0] val);
        cfg_write <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (sel)
            gcs_pkg::CFG_WRAP_MODE:      wrap_q  = val[1:0];
            gcs_pkg::CFG_SCALE:          scale_q = val;
            gcs_pkg::CFG_INDEX_MASK:     mask_q  = val[3:0];
            gcs_pkg::CFG_ENTRIES_IN_USE: count_q = val[4:0];
            default:                     ;
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    // free stretches of random length, stalls mostly short with a few long ones
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(20, 60)) @(posedge clk);
            else
                repeat ($urandom_range(1, 6)) @(posedge clk);
            out_stall <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(10, 30)) @(posedge clk);
            else
                repeat ($urandom_range(1, 3)) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : check_colors
        color_t got;
        color_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {out_red, out_green, out_blue, out_alpha};
            if (pending_colors.size() == 0)
                flag_failure($sformatf("color %h %h %h %h with no sample pending",
                                       got.red, got.green, got.blue, got.alpha));
            else
            begin
                want = pending_colors.pop_front();
                colors_checked++;
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.alpha !== want.alpha)
                    flag_failure($sformatf("expected %h %h %h %h, got %h %h %h %h",
                                           want.red, want.green, want.blue, want.alpha,
                                           got.red, got.green, got.blue, got.alpha));
            end
        end
    end

    initial
    begin
        step_t       s;
        logic [1:0]  mode;
        logic [15:0] scl;
        logic [3:0]  msk;
        logic [4:0]  cnt;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        operation   = gcs_pkg::OP_SAMPLE;
        position    = '0;
        entry_index = '0;
        entry_red   = '0;
        entry_green = '0;
        entry_blue  = '0;
        entry_alpha = '0;
        cfg_write   = 1'b0;
        cfg_index   = gcs_pkg::CFG_WRAP_MODE;
        cfg_data    = '0;
        failures       = 0;
        cycles         = 0;
        samples_sent   = 0;
        loads_sent     = 0;
        reg_writes     = 0;
        colors_checked = 0;
        wrap_q  = gcs_pkg::WRAP_REPEAT;
        scale_q = gcs_pkg::SCALE_RESET;
        mask_q  = gcs_pkg::MASK_RESET;
        count_q = gcs_pkg::COUNT_RESET;
        for (int i = 0; i < gcs_pkg::TABLE_DEPTH; i++)
            palette[i] = '0;

        directed_plan = '{
            load_row(4'd0,  {16'h0000, 16'h0000, 16'h0000, 16'h0000}),
            load_row(4'd1,  {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000}),
            load_row(4'd2,  {16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF}),
            load_row(4'd3,  {16'h1111, 16'h2222, 16'h3333, 16'h4444}),
            load_row(4'd4,  {16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE}),
            load_row(4'd5,  {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}),
            load_row(4'd6,  {16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0}),
            load_row(4'd7,  {16'h0F0F, 16'hF0F0, 16'h00FF, 16'hFF00}),
            load_row(4'd8,  {16'h8001, 16'h4002, 16'h2003, 16'h1004}),
            load_row(4'd9,  {16'h7777, 16'h8888, 16'h9999, 16'h6666}),
            load_row(4'd10, {16'hA5A5, 16'h5A5A, 16'h3C3C, 16'hC3C3}),
            load_row(4'd11, {16'h0102, 16'h0304, 16'h0506, 16'h0708}),
            load_row(4'd12, {16'hFEDC, 16'hBA98, 16'h7654, 16'h3210}),
            load_row(4'd13, {16'h2468, 16'hACE0, 16'h1357, 16'h9BDF}),
            load_row(4'd14, {16'hC000, 16'h4000, 16'hE000, 16'h2000}),
            load_row(4'd15, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}),
            sample_row_is(24'h000000, {4{16'h0000}}),
            sample_row(24'h7FFFFF),
            sample_row(24'h800000),
            reg_row(gcs_pkg::CFG_WRAP_MODE, {14'd0, gcs_pkg::WRAP_REFLECT}),
            sample_row(24'h010000),
            reg_row(gcs_pkg::CFG_WRAP_MODE, {14'd0, gcs_pkg::WRAP_CLAMP}),
            sample_row_is(24'h000000, {4{16'h0000}}),
            sample_row_is(24'h010000, {4{16'hFFFF}}),
            sample_row(24'h008000),
            reg_row(gcs_pkg::CFG_ENTRIES_IN_USE, 16'd0),
            sample_row_is(24'h7FFFFF, {4{16'h0000}}),
            reg_row(gcs_pkg::CFG_ENTRIES_IN_USE, 16'd31),
            sample_row_is(24'h010000, {4{16'hFFFF}}),
            reg_row(gcs_pkg::CFG_WRAP_MODE, {14'd0, WRAP_UNUSED}),
            sample_row_is(24'h800000, {4{16'h0000}}),
            reg_row(gcs_pkg::CFG_ENTRIES_IN_USE, 16'd5),
            sample_row_is(24'h020000, {16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE})
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].is_cfg)
            begin
                quiesce();
                write_reg(directed_plan[i].reg_sel, directed_plan[i].reg_val);
            end
            else
            begin
                issue(directed_plan[i]);
                idle_gap(1'b0);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            mode = 2'(ph % 4);
            case (ph)
                0:
                begin
                    scl = 16'h0000;
                    msk = 4'h0;
                    cnt = 5'd1;
                end
                1:
                begin
                    scl = 16'hFFFF;
                    msk = 4'hF;
                    cnt = 5'd31;
                end
                default:
                begin
                    scl = pick_scale();
                    msk = 4'($urandom_range(0, 15));
                    cnt = 5'($urandom_range(0, 31));
                end
            endcase
            quiesce();
            write_reg(gcs_pkg::CFG_WRAP_MODE, {14'd0, mode});
            write_reg(gcs_pkg::CFG_SCALE, scl);
            write_reg(gcs_pkg::CFG_INDEX_MASK, {12'd0, msk});
            write_reg(gcs_pkg::CFG_ENTRIES_IN_USE, {11'd0, cnt});
            for (int n = 0; n < PER_PHASE; n++)
            begin
                s       = '0;
                s.op    = ($urandom_range(0, 3) == 0) ? gcs_pkg::OP_LOAD : gcs_pkg::OP_SAMPLE;
                s.pos   = pick_position();
                s.idx   = 4'($urandom_range(0, 15));
                s.color = {pick_channel(), pick_channel(), pick_channel(), pick_channel()};
                issue(s);
                idle_gap(ph % 3 == 2);
            end
        end

        in_valid <= 1'b0;
        while (pending_colors.size() != 0)
            @(posedge clk);
        repeat (4 * SETTLE) @(posedge clk);
        if (pending_colors.size() != 0)
            flag_failure($sformatf("%0d colors never arrived", pending_colors.size()));

        $display("sent %0d samples and %0d table loads across %0d register writes",
                 samples_sent, loads_sent, reg_writes);
        $display("checked %0d colors, %0d failures, %0d cycles",
                 colors_checked, failures, cycles);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
